### rtl/core/tpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpb_pkg
// Shared constants, request type and pixel index math for the bitplane packer.
// ----------------------------------------------------------------------------
package tpb_pkg;

	// frame geometry
	localparam int COLUMNS     = 256;
	localparam int ROWS        = 128;
	localparam int PIXELS      = COLUMNS * ROWS;
	localparam int PLANE_BYTES = (PIXELS + 7) / 8;

	// widths
	localparam int PIX_W  = $clog2(PIXELS);
	localparam int MEM_AW = $clog2(PLANE_BYTES);
	localparam int BYTE_W = 8;
	localparam int ENTRY_W = 2 * BYTE_W;

	// request operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// pixel codes
	localparam logic [1:0] PIX_BLACK = 2'd1;
	localparam logic [1:0] PIX_RED   = 2'd2;

	// decoded request handed from the front end to the plane pipeline
	typedef struct packed {
		logic              rd;
		logic              ok;
		logic [MEM_AW-1:0] addr;
		logic [BYTE_W-1:0] mask;
		logic [1:0]        code;
	} req_t;

	// mirrored column-major pixel index
	function automatic logic [PIX_W-1:0] pix_index(input logic [7:0] column,
		input logic [6:0] row);
		logic [PIX_W-1:0] mirror;
		logic [PIX_W-1:0] prod;
		mirror = PIX_W'(COLUMNS - 1) - PIX_W'(column);
		prod   = PIX_W'(mirror * PIX_W'(ROWS));
		return prod + PIX_W'(row);
	endfunction

endpackage

### rtl/core/tpb_pixel_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpb_pixel_map
// Decodes an input request into plane byte address, bit mask and range flag.
// ----------------------------------------------------------------------------
module tpb_pixel_map import tpb_pkg::*; (
	input  logic        op,
	input  logic [7:0]  column,
	input  logic [6:0]  row,
	input  logic [1:0]  pixel_code,
	input  logic [11:0] byte_index,
	output req_t        req
);

	logic [PIX_W-1:0] pix;
	logic             col_ok;
	logic             row_ok;
	logic             pix_ok;
	logic             rd_ok;

	// pixel position in the mirrored plane
	assign pix    = pix_index(column, row);
	assign col_ok = 32'(column) < 32'(COLUMNS);
	assign row_ok = 32'(row) < 32'(ROWS);
	assign pix_ok = 32'(pix >> 3) < 32'(PLANE_BYTES);
	assign rd_ok  = 32'(byte_index) < 32'(PLANE_BYTES);

	// request fields, MSB of a byte is the lowest pixel index
	always_comb begin
		req.rd   = (op == OP_READ);
		req.code = pixel_code;
		req.mask = 8'h80 >> pix[2:0];
		if (op == OP_READ) begin
			req.ok   = rd_ok;
			req.addr = MEM_AW'(byte_index);
		end else begin
			req.ok   = col_ok && row_ok && pix_ok;
			req.addr = MEM_AW'(pix >> 3);
		end
	end

endmodule

### rtl/core/tpb_plane_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpb_plane_ram
// Plane store: one write port, one registered read port, clearing pass after
// reset.
// ----------------------------------------------------------------------------
module tpb_plane_ram import tpb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [MEM_AW-1:0]  rd_addr,
	output logic [ENTRY_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [MEM_AW-1:0]  wr_addr,
	input  logic [ENTRY_W-1:0] wr_data,
	output logic               clr_busy
);

	logic [ENTRY_W-1:0] mem [PLANE_BYTES];
	logic [MEM_AW-1:0]  clr_addr_q;
	logic               clr_busy_q;
	logic [ENTRY_W-1:0] rd_data_q;

	// clearing sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == MEM_AW'(PLANE_BYTES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// write port, sweep has priority
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clr_busy = clr_busy_q;

endmodule

### rtl/core/tricolor_pixel_to_bitplanes_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tricolor_pixel_to_bitplanes_top
// Packs three-color pixels into black and red bitplanes and reads them back.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one request: op selects a pixel
// write (column, row, pixel_code) or a byte read (byte_index). Writes land at
// pixel (COLUMNS-1-column)*ROWS+row, MSB-first in each plane byte; they give
// no result. Each read gives one result on the output channel
// (out_valid / out_stall): black_byte and red_byte at that byte address,
// zero for an address past the plane.
// Throughput: one request per cycle while in_stall is low, set by the single
// read and single write port of the plane memory; a read-modify-write reads
// on accept, writes from stage 1, and the byte written is forwarded to the
// next request's read. A read result is registered in stage 1, then in the
// output register.
// Reset: both planes are cleared by a sweep over all 4096 (PLANE_BYTES)
// entries, during which in_stall is held high.
// A stalled output holds its result; the pipeline keeps taking writes and
// stops only when a read reaches the full output register.
// ----------------------------------------------------------------------------
module tricolor_pixel_to_bitplanes_top import tpb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [7:0]  column,
	input  logic [6:0]  row,
	input  logic [1:0]  pixel_code,
	input  logic [11:0] byte_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  black_byte,
	output logic [7:0]  red_byte
);

	req_t               req;
	req_t               req_s1;
	logic               valid_s1;
	logic               in_accept;
	logic               go;
	logic               clr_busy;
	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] cur;
	logic [ENTRY_W-1:0] new_entry;
	logic               wr_en;
	logic               fwd_valid_q;
	logic [MEM_AW-1:0]  fwd_addr_q;
	logic [ENTRY_W-1:0] fwd_data_q;
	logic               out_valid_q;
	logic [7:0]         black_q;
	logic [7:0]         red_q;

	// request decode
	tpb_pixel_map u_map (
		.op         (op),
		.column     (column),
		.row        (row),
		.pixel_code (pixel_code),
		.byte_index (byte_index),
		.req        (req)
	);

	// handshake
	assign go        = !req_s1.rd || !out_valid_q || !out_stall;
	assign in_stall  = clr_busy || (valid_s1 && !go);
	assign in_accept = in_valid && !in_stall;

	// plane memory, read issued on accept
	tpb_plane_ram u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_accept),
		.rd_addr  (req.addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (req_s1.addr),
		.wr_data  (new_entry),
		.clr_busy (clr_busy)
	);

	// stage 1 request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_s1 <= req;
		end
	end

	// forward the byte written at the same edge as this read
	assign cur = (fwd_valid_q && fwd_addr_q == req_s1.addr) ? fwd_data_q : rd_data;

	// modify: black sets black and clears red, red sets red, white and code 3 clear both
	always_comb begin
		case (req_s1.code)
			PIX_BLACK: new_entry = {cur[15:8] | req_s1.mask, cur[7:0] & ~req_s1.mask};
			PIX_RED:   new_entry = {cur[15:8], cur[7:0] | req_s1.mask};
			default:   new_entry = {cur[15:8] & ~req_s1.mask, cur[7:0] & ~req_s1.mask};
		endcase
	end

	assign wr_en = valid_s1 && !req_s1.rd && req_s1.ok;

	// last write, kept for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= req_s1.addr;
			fwd_data_q <= new_entry;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && req_s1.rd && go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && req_s1.rd && go) begin
			black_q <= req_s1.ok ? cur[15:8] : 8'h00;
			red_q   <= req_s1.ok ? cur[7:0] : 8'h00;
		end
	end

	assign out_valid  = out_valid_q;
	assign black_byte = black_q;
	assign red_byte   = red_q;

	// no plane write while the clearing sweep runs
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !wr_en)
		else $error("plane write during clearing sweep");

	// a read blocked in stage 1 stays there unchanged
	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && req_s1.rd && !go) |=> (valid_s1 && $stable(req_s1)))
		else $error("blocked read lost from stage 1");

	// a read leaving stage 1 shows up at the output
	a_read_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && req_s1.rd && go) |=> out_valid)
		else $error("read result not presented");

endmodule
